>>> hdl/rgtm_pkg.sv
// ----------------------------------------------------------------------------
// rgtm_pkg: shared constants for the Reinhard / sqrt gamma tone mapper
// Default fixed-point format, register indexes and output byte limits.
// ----------------------------------------------------------------------------
package rgtm_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int INT_BITS_DEF  = 8;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_REINHARD_EN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAMMA_EN    = 1'd1;

  localparam int         BYTE_W   = 8;
  localparam logic [7:0] BYTE_MAX = 8'd255;
  localparam int         CHAN_NUM = 3;

endpackage

>>> hdl/reinhard_gamma_pixel_tonemap_core.sv
// ----------------------------------------------------------------------------
// reinhard_gamma_pixel_tonemap_core: HDR pixel to display bytes
// Optional x/(1+x) curve, optional square-root gamma, scale by 255, clamp.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall carry one item, a pixel of three
//   unsigned Q(INT).(FRAC) channels, Q8.16 by default, plus a frame-last flag.
//   Output channel: out_valid / out_stall carry one item of three bytes and
//   the copied frame-end flag. One result per input item, in order.
//   Config: cfg_we, cfg_index, cfg_wdata; bit 0 of data is kept. Index 0 is
//   the curve enable, index 1 the gamma enable. Both reset to 1. Write only
//   while the pipeline is empty.
// Throughput: one item per clock while no stall freezes the pipeline. The
//   pipeline runs through the input register, the restoring divider (one
//   quotient bit per stage), the square-root load, the restoring square root
//   (one root bit per stage), a multiply stage and the output register.
// Reset (synchronous, rst_n low) empties the pipeline and sets both enables.
// Stall: the whole pipeline freezes when the output holds an item and
//   out_stall is high; in_stall is raised in that same cycle. Bubbles move
//   along with the data.
// ----------------------------------------------------------------------------
module reinhard_gamma_pixel_tonemap_core #(
  parameter int FRAC_BITS = rgtm_pkg::FRAC_BITS_DEF,
  parameter int INT_BITS  = rgtm_pkg::INT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rgtm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgtm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [INT_BITS+FRAC_BITS-1:0] in_red_in,
  input  logic [INT_BITS+FRAC_BITS-1:0] in_green_in,
  input  logic [INT_BITS+FRAC_BITS-1:0] in_blue_in,
  input  logic                          in_frame_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rgtm_pkg::BYTE_W-1:0]   out_red_byte,
  output logic [rgtm_pkg::BYTE_W-1:0]   out_green_byte,
  output logic [rgtm_pkg::BYTE_W-1:0]   out_blue_byte,
  output logic                          out_frame_end
);

  localparam int CW  = INT_BITS + FRAC_BITS;        // channel width
  localparam int NB  = (CW + FRAC_BITS + 1) / 2;    // root bits
  localparam int NW  = 2 * NB;                      // radicand width
  localparam int RW  = NB + 2;                      // sqrt remainder
  localparam int PW  = CW + 8;                      // 255 * g
  localparam int NC  = rgtm_pkg::CHAN_NUM;
  // stage map: 0 input, 1..F divide, F+1 sqrt load, then NB root steps,
  // product, output
  localparam int SQ0 = FRAC_BITS + 1;
  localparam int SPR = SQ0 + NB + 1;
  localparam int NST = SPR + 2;

  logic reinhard_en_r, gamma_en_r;
  logic adv;

  logic vld_r  [0:NST-1];
  logic last_r [0:NST-1];

  // divider: remainder, divisor (x + one), quotient, raw x for bypass
  logic [CW:0]          drem_r [0:FRAC_BITS][0:NC-1];
  logic [CW:0]          dden_r [0:FRAC_BITS][0:NC-1];
  logic [FRAC_BITS-1:0] dquo_r [0:FRAC_BITS][0:NC-1];
  logic [CW-1:0]        draw_r [0:FRAC_BITS][0:NC-1];

  // square root: radicand shifter, remainder, root, curve output for bypass
  logic [NW-1:0] srad_r [0:NB][0:NC-1];
  logic [RW-1:0] srem_r [0:NB][0:NC-1];
  logic [NB-1:0] sroot_r[0:NB][0:NC-1];
  logic [CW-1:0] sy_r   [0:NB][0:NC-1];

  logic [PW-1:0] prod_r [0:NC-1];
  logic [rgtm_pkg::BYTE_W-1:0] byte_r [0:NC-1];

  logic [CW-1:0] pix_in [0:NC-1];

  assign pix_in[0] = in_red_in;
  assign pix_in[1] = in_green_in;
  assign pix_in[2] = in_blue_in;

  // global advance: freeze only when a finished item is held
  assign adv      = !(vld_r[NST-1] && out_stall);
  assign in_stall = !adv;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reinhard_en_r <= 1'b1;
      gamma_en_r    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        rgtm_pkg::REG_REINHARD_EN: reinhard_en_r <= cfg_wdata[0];
        rgtm_pkg::REG_GAMMA_EN:    gamma_en_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // valid / frame flag shift line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NST; s++) vld_r[s] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int s = 1; s < NST; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last_r[0] <= in_frame_last;
      for (int s = 1; s < NST; s++) last_r[s] <= last_r[s-1];
    end
  end

  // stage 0: latch x, divisor x + one; start remainder at x (x < divisor)
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < NC; c++) begin
        drem_r[0][c] <= {1'b0, pix_in[c]};
        dden_r[0][c] <= {1'b0, pix_in[c]} + ((CW+1)'(1) << FRAC_BITS);
        dquo_r[0][c] <= '0;
        draw_r[0][c] <= pix_in[c];
      end
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_div
    for (genvar c = 0; c < NC; c++) begin : g_ch
      logic [CW+1:0] trial;
      logic          take;
      assign trial = {drem_r[k-1][c], 1'b0};
      assign take  = trial >= {1'b0, dden_r[k-1][c]};
      always_ff @(posedge clk) begin
        if (adv) begin
          drem_r[k][c] <= take ? (CW+1)'(trial - {1'b0, dden_r[k-1][c]})
                               : trial[CW:0];
          dden_r[k][c] <= dden_r[k-1][c];
          dquo_r[k][c] <= {dquo_r[k-1][c][FRAC_BITS-2:0], take};
          draw_r[k][c] <= draw_r[k-1][c];
        end
      end
    end
  end

  // sqrt load: pick curve or raw, radicand = y << FRAC
  for (genvar c = 0; c < NC; c++) begin : g_sql
    logic [CW-1:0] ysel;
    assign ysel = reinhard_en_r ? CW'(dquo_r[FRAC_BITS][c])
                                : draw_r[FRAC_BITS][c];
    always_ff @(posedge clk) begin
      if (adv) begin
        srad_r[0][c]  <= NW'(ysel) << FRAC_BITS;
        srem_r[0][c]  <= '0;
        sroot_r[0][c] <= '0;
        sy_r[0][c]    <= ysel;
      end
    end
  end

  // restoring square root, two radicand bits in, one root bit out per stage
  for (genvar j = 1; j <= NB; j++) begin : g_sqrt
    for (genvar c = 0; c < NC; c++) begin : g_ch
      logic [RW+1:0] rsh;
      logic [RW+1:0] tst;
      logic          take;
      assign rsh  = {srem_r[j-1][c], srad_r[j-1][c][NW-1:NW-2]};
      assign tst  = {2'b00, sroot_r[j-1][c], 2'b01};
      assign take = rsh >= tst;
      always_ff @(posedge clk) begin
        if (adv) begin
          srem_r[j][c]  <= take ? RW'(rsh - tst) : rsh[RW-1:0];
          sroot_r[j][c] <= {sroot_r[j-1][c][NB-2:0], take};
          srad_r[j][c]  <= srad_r[j-1][c] << 2;
          sy_r[j][c]    <= sy_r[j-1][c];
        end
      end
    end
  end

  // 255 * g, then scale down and clamp
  for (genvar c = 0; c < NC; c++) begin : g_out
    logic [CW-1:0]           gsel;
    logic [PW-FRAC_BITS-1:0] bfull;
    assign gsel  = gamma_en_r ? CW'(sroot_r[NB][c]) : sy_r[NB][c];
    assign bfull = prod_r[c][PW-1:FRAC_BITS];
    always_ff @(posedge clk) begin
      if (adv) begin
        prod_r[c] <= PW'(gsel) * PW'(rgtm_pkg::BYTE_MAX);
        byte_r[c] <= (bfull > (PW-FRAC_BITS)'(rgtm_pkg::BYTE_MAX))
                     ? rgtm_pkg::BYTE_MAX : bfull[rgtm_pkg::BYTE_W-1:0];
      end
    end
  end

  assign out_valid      = vld_r[NST-1];
  assign out_red_byte   = byte_r[0];
  assign out_green_byte = byte_r[1];
  assign out_blue_byte  = byte_r[2];
  assign out_frame_end  = last_r[NST-1];

  // ---------------------------------------------------------------- checks
  // pipeline is empty right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("output valid after reset");

  // an accepted item lands in the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[0]) else $error("accepted item lost");

  // a held output item stays until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red_byte))
    else $error("held item dropped or changed");

  // an empty output stage is filled by the item right behind it
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NST-2] && !vld_r[NST-1] |=> out_valid)
    else $error("item skipped output stage");

endmodule
